// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that a property holds at every rising clock edge out of reset
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assert that a condition never holds at a rising clock edge out of reset
`define CHK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== rtl/apu_pkg.sv =====
// Package: constants, types and float compare for the argmax pooling unit
package apu_pkg;
  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_POOL = 256;
  localparam int CH_W = $clog2(MAX_CHANNELS);
  localparam int EL_W = $clog2(MAX_POOL);
  localparam int VAL_W = 32;
  localparam int CFG_W = 11;
  localparam int CNT_CH_W = 11;
  localparam int CNT_EL_W = 9;
  localparam logic [0:0] REG_CHANNEL_COUNT = 1'b0;
  localparam logic [0:0] REG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] sample;
    logic [CH_W-1:0]  chan;
    logic [EL_W-1:0]  elem;
    logic             seed;
    logic             emit;
    logic             last_ch;
  } op_t;

  function automatic logic f32_greater(input logic [31:0] a, input logic [31:0] b);
    logic na, nb;
    logic [31:0] ka, kb;
    na = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nb = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (na || nb) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    return ka > kb;
  endfunction
endpackage

// ===== rtl/apu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module apu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/apu_front.sv =====
// Front end: accept samples, track channel/element position, classify
module apu_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_sel,
  input  logic                      cfg_hit,
  input  logic [apu_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [31:0]               in_sample_value,
  output logic                      op_valid,
  input  logic                      op_stall,
  output apu_pkg::op_t              op
);
  logic [apu_pkg::CNT_CH_W-1:0] ch_cnt_r, ch_cnt_nxt;
  logic [apu_pkg::CNT_EL_W-1:0] pool_r, pool_nxt;
  logic [apu_pkg::CH_W-1:0] chan_r, chan_nxt;
  logic [apu_pkg::EL_W-1:0] elem_r, elem_nxt;
  logic [apu_pkg::CNT_CH_W-1:0] ch_in;
  logic [apu_pkg::CNT_EL_W-1:0] pl_in;
  logic last_ch, last_el, acc;

  assign in_stall = op_stall;
  assign op_valid = in_valid;
  assign acc = in_valid && !op_stall;
  assign last_ch = ({1'b0, chan_r} + 11'd1) >= ch_cnt_r;
  assign last_el = ({1'b0, elem_r} + 9'd1) >= pool_r;
  assign ch_in = cfg_wdata[apu_pkg::CNT_CH_W-1:0];
  assign pl_in = cfg_wdata[apu_pkg::CNT_EL_W-1:0];

  always_comb begin
    op.sample  = in_sample_value;
    op.chan    = chan_r;
    op.elem    = elem_r;
    op.seed    = (elem_r == '0);
    op.emit    = last_el;
    op.last_ch = last_ch;
  end

  always_comb begin
    ch_cnt_nxt = ch_cnt_r;
    pool_nxt = pool_r;
    chan_nxt = chan_r;
    elem_nxt = elem_r;
    if (cfg_we && cfg_hit) begin
      case (cfg_sel)
        apu_pkg::REG_CHANNEL_COUNT: begin
          if (ch_in == '0) ch_cnt_nxt = 11'd1;
          else if (ch_in > 11'(apu_pkg::MAX_CHANNELS)) ch_cnt_nxt = 11'(apu_pkg::MAX_CHANNELS);
          else ch_cnt_nxt = ch_in;
        end
        apu_pkg::REG_POOL_SIZE: begin
          if (pl_in == '0) pool_nxt = 9'd1;
          else if (pl_in > 9'(apu_pkg::MAX_POOL)) pool_nxt = 9'(apu_pkg::MAX_POOL);
          else pool_nxt = pl_in;
        end
        default: ;
      endcase
      chan_nxt = '0;
      elem_nxt = '0;
    end else if (acc) begin
      if (last_ch) begin
        chan_nxt = '0;
        elem_nxt = last_el ? '0 : elem_r + 1'b1;
      end else begin
        chan_nxt = chan_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_cnt_r <= 11'd1;
      pool_r <= 9'd1;
      chan_r <= '0;
      elem_r <= '0;
    end else begin
      ch_cnt_r <= ch_cnt_nxt;
      pool_r <= pool_nxt;
      chan_r <= chan_nxt;
      elem_r <= elem_nxt;
    end
  end
endmodule

// ===== rtl/apu_queue.sv =====
// Two-entry queue between front and back ends
module apu_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_stall,
  input  apu_pkg::op_t wr_op,
  output logic         rd_valid,
  input  logic         rd_take,
  output apu_pkg::op_t rd_op
);
  apu_pkg::op_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rp_r, wp_r;
  logic push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign push = wr_valid && !wr_stall;
  assign rd_valid = (cnt_r != 2'd0);
  assign pop = rd_valid && rd_take;
  assign rd_op = ent_r[rp_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wr_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rp_r <= 1'b0;
      wp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
    end
  end
endmodule

// ===== rtl/apu_back.sv =====
// Back end: read-modify-write of per-channel best entry with forwarding
module apu_back (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         op_valid,
  output logic         op_take,
  input  apu_pkg::op_t op,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [31:0]  out_max_value,
  output logic [7:0]   out_max_index,
  output logic [9:0]   out_channel_number,
  output logic         out_pixel_last
);
  // stage 1: RAM read issued; stage 2: compare and write back
  logic s1_v_r;
  apu_pkg::op_t s1_r;
  logic [31:0] rd_val;
  logic [7:0] rd_idx;
  logic [31:0] old_val, new_val;
  logic [7:0] old_idx, new_idx;
  logic upd, s1_go, adv, fwd_v_r;
  logic [9:0] fwd_ch_r;
  logic [31:0] fwd_val_r;
  logic [7:0] fwd_idx_r;
  logic ov_r;

  // output register full and stalled holds the back end
  assign adv = !(ov_r && out_stall);
  assign op_take = adv;
  assign s1_go = op_valid && adv;

  always_comb begin
    old_val = rd_val;
    old_idx = rd_idx;
    if (fwd_v_r && fwd_ch_r == s1_r.chan) begin
      old_val = fwd_val_r;
      old_idx = fwd_idx_r;
    end
    upd = s1_r.seed || apu_pkg::f32_greater(s1_r.sample, old_val);
    new_val = upd ? s1_r.sample : old_val;
    new_idx = upd ? s1_r.elem : old_idx;
  end

  apu_ram #(.WIDTH(32), .DEPTH(apu_pkg::MAX_CHANNELS)) u_val (
    .clk(clk), .we(s1_v_r && adv), .waddr(s1_r.chan), .wdata(new_val),
    .re(s1_go), .raddr(op.chan), .rdata(rd_val)
  );
  apu_ram #(.WIDTH(8), .DEPTH(apu_pkg::MAX_CHANNELS)) u_idx (
    .clk(clk), .we(s1_v_r && adv), .waddr(s1_r.chan), .wdata(new_idx),
    .re(s1_go), .raddr(op.chan), .rdata(rd_idx)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= op;
      fwd_ch_r <= s1_r.chan;
      fwd_val_r <= new_val;
      fwd_idx_r <= new_idx;
      if (s1_v_r && s1_r.emit) begin
        out_max_value <= new_val;
        out_max_index <= new_idx;
        out_channel_number <= s1_r.chan;
        out_pixel_last <= s1_r.last_ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= op_valid;
      fwd_v_r <= s1_v_r;
      ov_r <= s1_v_r && s1_r.emit;
    end
  end

  assign out_valid = ov_r;
endmodule

// ===== rtl/argmax_pooling_unit.sv =====
// Path from the input accept edge to out_valid: queue entry, then the registered RAM read,
// then compare into the output register.
// Throughput: one item per cycle while out_stall does not hold the output; one RAM read
// and one write-back per cycle, with forwarding of the previous write to the same channel.
// Reset: synchronous active-low rst_n clears positions, counts and valids;
// channel_count and pool_size reset to 1. Best-value RAMs are not cleared.
module argmax_pooling_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [10:0]  cfg_wdata,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [31:0]  in_sample_value,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [31:0]  out_max_value,
  output logic [7:0]   out_max_index,
  output logic [9:0]   out_channel_number,
  output logic         out_pixel_last
);
  logic f_valid, f_stall, q_valid, q_take;
  apu_pkg::op_t f_op, q_op;

  apu_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_sel(cfg_index), .cfg_hit(1'b1),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_value(in_sample_value), .op_valid(f_valid), .op_stall(f_stall), .op(f_op)
  );
  apu_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall), .wr_op(f_op),
    .rd_valid(q_valid), .rd_take(q_take), .rd_op(q_op)
  );
  apu_back u_back (
    .clk(clk), .rst_n(rst_n), .op_valid(q_valid), .op_take(q_take), .op(q_op),
    .out_valid(out_valid), .out_stall(out_stall), .out_max_value(out_max_value),
    .out_max_index(out_max_index), .out_channel_number(out_channel_number),
    .out_pixel_last(out_pixel_last)
  );
endmodule

// ===== rtl/apu_checker.sv =====
// Port-level checker for the argmax pooling unit, bound to the top level
`include "assert_macros.svh"
module apu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_max_value,
  input logic [9:0]  out_channel_number,
  input logic        cfg_we,
  input logic        in_valid
);
  `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `CHK_ASSERT(a_val_hold, out_valid && out_stall |=> $stable(out_max_value), "value changed")
  `CHK_ASSERT(a_chan_hold, out_valid && out_stall |=> $stable(out_channel_number), "channel changed")
  `CHK_NEVER(a_cfg_idle, cfg_we && (in_valid || out_valid), "config write with items in flight")
endmodule

bind argmax_pooling_unit apu_checker u_apu_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_max_value(out_max_value), .out_channel_number(out_channel_number),
  .cfg_we(cfg_we), .in_valid(in_valid)
);

// ===== tb/argmax_pooling_unit_tb.sv =====
// Self-checking testbench for the argmax pooling unit: table-driven and random pixels
`timescale 1ns / 1ps
module argmax_pooling_unit_tb;

  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  index;
    logic [9:0]  chan;
    logic        last;
  } pool_result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [0:0]  reg_sel;
    logic [10:0] cfg_data;
    logic [31:0] sample;
    logic        has_exp;
    logic [31:0] exp_value;
    logic [7:0]  exp_index;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = apu_pkg::REG_CHANNEL_COUNT;
  logic [10:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_sample_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_max_value;
  logic [7:0] out_max_index;
  logic [9:0] out_channel_number;
  logic out_pixel_last;

  argmax_pooling_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] best_val [apu_pkg::MAX_CHANNELS];
  logic [7:0] best_idx [apu_pkg::MAX_CHANNELS];
  int unsigned chan_pos, elem_pos, n_chan, n_pool;
  pool_result_t pending_q[$];
  int errors = 0;
  int table_errors = 0;
  int cycles = 0;
  int hold_off = 0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;
  bit rx_idle_gaps = 1'b1;

  function automatic bit is_nan(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 0;
  endfunction

  function automatic logic [31:0] order_of(logic [31:0] v);
    return v[31] ? ~v : {1'b1, v[30:0]};
  endfunction

  function automatic bit beats(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    return order_of(a) > order_of(b);
  endfunction

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return v > hi ? hi : v;
  endfunction

  task automatic predict_config(logic [0:0] r, logic [10:0] d);
    if (r == apu_pkg::REG_CHANNEL_COUNT) n_chan = clamp(d, apu_pkg::MAX_CHANNELS);
    else n_pool = clamp(d[8:0], apu_pkg::MAX_POOL);
    chan_pos = 0;
    elem_pos = 0;
  endtask

  task automatic predict_sample(logic [31:0] s);
    pool_result_t r;
    if (elem_pos == 0 || beats(s, best_val[chan_pos])) begin
      best_val[chan_pos] = s;
      best_idx[chan_pos] = elem_pos[7:0];
    end
    if (elem_pos + 1 >= n_pool) begin
      r.value = best_val[chan_pos];
      r.index = best_idx[chan_pos];
      r.chan = chan_pos[9:0];
      r.last = chan_pos + 1 >= n_chan;
      pending_q.push_back(r);
    end
    chan_pos++;
    if (chan_pos >= n_chan) begin
      chan_pos = 0;
      elem_pos = (elem_pos + 1 >= n_pool) ? 0 : elem_pos + 1;
    end
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 1) == 0) n = 0;
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] r, logic [10:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    predict_config(r, d);
  endtask

  task automatic send_sample(logic [31:0] s);
    in_valid <= 1'b1;
    in_sample_value <= s;
    do @(posedge clk); while (in_stall);
    predict_sample(s);
  endtask

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 3))};
      2: return {$urandom_range(0, 1) == 1, 31'd0};
      3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};
      default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(125, 129)),
                       23'($urandom_range(0, 7))};
    endcase
  endfunction

  // directed: reset config, zeros, NaN, extremes, saturation, mid-pixel rewrite
  stim_row_t table_rows[] = '{
    '{1'b0, 1'b0, 11'd0, 32'h3F800000, 1'b1, 32'h3F800000, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 8'd0},
    '{1'b1, apu_pkg::REG_POOL_SIZE, 11'd3, 32'h0, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h80000000, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h00000000, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'hBF800000, 1'b1, 32'h80000000, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h7FC00000, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h7F800000, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h7F7FFFFF, 1'b1, 32'h7FC00000, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'hFF800000, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h7F800000, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h7F800000, 1'b1, 32'h7F800000, 8'd1},
    '{1'b1, apu_pkg::REG_CHANNEL_COUNT, 11'd2, 32'h0, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h00000001, 1'b0, 32'h0, 8'd0},
    '{1'b1, apu_pkg::REG_POOL_SIZE, 11'd0, 32'h0, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h00000001, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h80000001, 1'b0, 32'h0, 8'd0},
    '{1'b1, apu_pkg::REG_CHANNEL_COUNT, 11'd2047, 32'h0, 1'b0, 32'h0, 8'd0},
    '{1'b1, apu_pkg::REG_POOL_SIZE, 11'd511, 32'h0, 1'b0, 32'h0, 8'd0},
    '{1'b1, apu_pkg::REG_CHANNEL_COUNT, 11'd0, 32'h0, 1'b0, 32'h0, 8'd0},
    '{1'b0, 1'b0, 11'd0, 32'h12345678, 1'b0, 32'h0, 8'd0}
  };

  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 200;
      out_stall <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_gaps && ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    pool_result_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_max_value, out_max_index, out_channel_number, out_pixel_last};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors + table_errors <= 10) $display("unexpected item: %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors + table_errors <= 10)
            $display("mismatch: exp val %h idx %0d ch %0d last %b, got %h %0d %0d %b",
                     want.value, want.index, want.chan, want.last,
                     got.value, got.index, got.chan, got.last);
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sent;
    int np, ncount, plen;
    n_chan = 1;
    n_pool = 1;
    chan_pos = 0;
    elem_pos = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (table_rows[i]) begin
      if (table_rows[i].is_cfg) begin
        write_reg(table_rows[i].reg_sel, table_rows[i].cfg_data);
      end else begin
        send_sample(table_rows[i].sample);
        if (table_rows[i].has_exp &&
            (pending_q.size() == 0 ||
             pending_q[$].value !== table_rows[i].exp_value ||
             pending_q[$].index !== table_rows[i].exp_index)) begin
          table_errors++;
          if (errors + table_errors <= 10)
            $display("table row %0d: expected %h idx %0d", i,
                     table_rows[i].exp_value, table_rows[i].exp_index);
        end
      end
    end
    // fill up the block under a long receiver hold-off
    write_reg(apu_pkg::REG_CHANNEL_COUNT, 11'd4);
    write_reg(apu_pkg::REG_POOL_SIZE, 11'd1);
    hold_start = 1'b1;
    repeat (40) send_sample($urandom());
    drain();
    sent = 0;
    while (sent < 1050) begin
      case ($urandom_range(0, 5))
        0: begin ncount = 1; plen = $urandom_range(1, 8); end
        1: begin ncount = $urandom_range(1, 16); plen = 1; end
        2: begin ncount = (sent < 200) ? 1 : 0; plen = 256; end
        default: begin ncount = $urandom_range(1, 6); plen = $urandom_range(2, 9); end
      endcase
      if (ncount == 0) begin ncount = 2; plen = $urandom_range(2, 5); end
      write_reg(apu_pkg::REG_CHANNEL_COUNT, 11'(ncount));
      write_reg(apu_pkg::REG_POOL_SIZE, 11'(plen));
      rx_idle_gaps = $urandom_range(0, 3) != 0;
      np = $urandom_range(1, 3);
      repeat (np * ncount * plen) begin
        if ($urandom_range(0, 1) == 0) idle_gap();
        send_sample(rand_float());
        sent++;
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 5)) send_sample(rand_float());
      end
    end
    rx_idle_gaps = 1'b1;
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && table_errors == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
